FILE: src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN evaluator package
// Character codes, status codes and control types shared by the evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // load from the neighbor nearer the top, or from the deeper neighbor
  typedef struct packed {
    logic push;
    logic pull;
  } cell_ctl_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: src/rpn_cell.sv
// ----------------------------------------------------------------------------
// RPN stack cell
// One stack entry; shifts toward the bottom on push, toward the top on pull.
// ----------------------------------------------------------------------------
module rpn_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  rpn_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] up_i,
  input  logic [DATA_WIDTH-1:0] down_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = up_i;
    end else if (ctl_i.pull) begin
      data_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/rpn_alu.sv
// ----------------------------------------------------------------------------
// RPN iterative arithmetic unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
module rpn_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  div_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  run_q, run_d, done_q, done_d, div_q, div_d, neg_q, neg_d;
  logic [DATA_WIDTH-1:0] mag_a, mag_b, trial, diff;

  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;
  assign trial = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
  assign diff  = trial - y_q;

  always_comb begin
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    div_d  = div_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      div_d = div_i;
      neg_d = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      x_d   = div_i ? mag_a : b_i;
      y_d   = div_i ? mag_b : a_i;
      cnt_d = CntW'(DATA_WIDTH);
      run_d = 1'b1;
    end else if (run_q) begin
      if (div_q) begin
        if (trial >= y_q) begin
          acc_d = diff;
          x_d   = {x_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_d = trial;
          x_d   = {x_q[DATA_WIDTH-2:0], 1'b0};
        end
      end else begin
        if (x_q[0]) begin
          acc_d = acc_q + y_q;
        end
        x_d = {1'b0, x_q[DATA_WIDTH-1:1]};
        y_d = {y_q[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~x_q + 1'b1) : x_q) : acc_q;

endmodule

FILE: src/rpn_expression_evaluator.sv
// ----------------------------------------------------------------------------
// RPN expression evaluator
// Reverse Polish calculator over ASCII characters, stack held in a cell chain.
// ----------------------------------------------------------------------------
// Digits, '+', '-', blanks and errors are handled without entering the busy state.
// '*' and '/' start the bit-serial arithmetic unit and stall input until it is done.
// '=' loads the output register; its result is visible the next cycle.
// Reset clears the depth count, the error and the output valid; the stack
// cells are not cleared, only entries below the count are ever read.
module rpn_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] value_o,
  output logic [2:0]            status_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic                  state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  rpn_pkg::status_e      err_q, err_d;
  logic [DATA_WIDTH-1:0] bottom_q, bottom_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;
  rpn_pkg::status_e      status_q, status_d;

  logic                  accept, push, pull, alu_start, alu_done;
  logic [DATA_WIDTH-1:0] top_in, alu_result, digit, opa, opb;
  logic [DATA_WIDTH-1:0] cell_q [STACK_DEPTH];

  assign digit = DATA_WIDTH'(char_code_i[3:0]);
  assign opb   = cell_q[0];
  assign opa   = cell_q[1];

  assign in_stall_o = (state_q == StBusy) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rpn_pkg::cell_ctl_t    ctl;
    logic [DATA_WIDTH-1:0] up, down;
    if (i == 0) begin : g_first
      assign ctl.push = push | pull;
      assign ctl.pull = 1'b0;
      assign up       = top_in;
      assign down     = cell_q[0];
    end else begin : g_rest
      assign ctl.push = push;
      assign ctl.pull = pull;
      assign up       = cell_q[i-1];
      assign down     = (i == STACK_DEPTH - 1) ? cell_q[i] : cell_q[(i + 1) % STACK_DEPTH];
    end
    rpn_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .up_i  (up),
      .down_i(down),
      .data_o(cell_q[i])
    );
  end

  rpn_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .div_i   (char_code_i == rpn_pkg::CH_DIV),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (alu_done),
    .result_o(alu_result)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    bottom_d    = bottom_q;
    out_valid_d = out_valid_q & out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    push        = 1'b0;
    pull        = 1'b0;
    alu_start   = 1'b0;
    top_in      = digit;
    if (state_q == StBusy) begin
      if (alu_done) begin
        pull    = 1'b1;
        top_in  = alu_result;
        count_d = count_q - 1'b1;
        state_d = StIdle;
        if (count_q == CntW'(2)) begin
          bottom_d = alu_result;
        end
      end
    end else if (accept && !rpn_pkg::is_blank(char_code_i)) begin
      if (char_code_i == rpn_pkg::CH_EQ) begin
        out_valid_d = 1'b1;
        if (err_q != rpn_pkg::ST_OK) begin
          value_d  = '0;
          status_d = err_q;
        end else if (count_q == '0) begin
          value_d  = '0;
          status_d = rpn_pkg::ST_EMPTY;
        end else begin
          value_d  = bottom_q;
          status_d = rpn_pkg::ST_OK;
        end
        count_d = '0;
        err_d   = rpn_pkg::ST_OK;
      end else if (err_q == rpn_pkg::ST_OK) begin
        if (char_code_i >= rpn_pkg::CH_ZERO && char_code_i <= rpn_pkg::CH_NINE) begin
          if (count_q == CntW'(STACK_DEPTH)) begin
            err_d = rpn_pkg::ST_OVERFLOW;
          end else begin
            push    = 1'b1;
            count_d = count_q + 1'b1;
            if (count_q == '0) begin
              bottom_d = digit;
            end
          end
        end else if (char_code_i == rpn_pkg::CH_ADD || char_code_i == rpn_pkg::CH_SUB ||
                     char_code_i == rpn_pkg::CH_MUL || char_code_i == rpn_pkg::CH_DIV) begin
          if (count_q < CntW'(2)) begin
            err_d = rpn_pkg::ST_UNDERFLOW;
          end else if (char_code_i == rpn_pkg::CH_DIV && opb == '0) begin
            err_d = rpn_pkg::ST_DIVZERO;
          end else if (char_code_i == rpn_pkg::CH_ADD || char_code_i == rpn_pkg::CH_SUB) begin
            pull    = 1'b1;
            top_in  = (char_code_i == rpn_pkg::CH_ADD) ? (opa + opb) : (opa - opb);
            count_d = count_q - 1'b1;
            if (count_q == CntW'(2)) begin
              bottom_d = top_in;
            end
          end else begin
            alu_start = 1'b1;
            state_d   = StBusy;
          end
        end else begin
          err_d = rpn_pkg::ST_INVALID;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      err_q       <= rpn_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bottom_q <= bottom_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) |-> in_stall_o) else $error("request taken while busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == StBusy)) else $error("arithmetic done outside busy");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH)) else $error("stack count beyond depth");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rpn_pkg::ST_OK) |-> (value_o == '0))
    else $error("nonzero value with error status");

endmodule
